// ===== rtl/core/hbm_pkg.sv =====
// Shared types, constants and helpers for the Hamming best-match block.
// No dependencies; imported by every module under rtl/core.
package hbm_pkg;

   localparam int unsigned DESC_WORDS     = 4;
   localparam int unsigned DESC_WORD_BITS = 64;
   localparam int unsigned WORD_POP_BITS  = 7;   // popcount of one 64-bit word, 0..64
   localparam int unsigned DIST_BITS      = 9;   // distance 0..256
   localparam int unsigned IDX_FIELD_BITS = 16;
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 64;

   localparam logic [DIST_BITS-1:0] DIST_NONE     = 9'd256;
   localparam logic [DIST_BITS-1:0] MAX_DIST_INIT = 9'd50;
   localparam logic [DIST_BITS-1:0] RATIO_INIT    = 9'd230;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_QUERY_WORD0  = 3'd0,
      CSR_QUERY_WORD1  = 3'd1,
      CSR_QUERY_WORD2  = 3'd2,
      CSR_QUERY_WORD3  = 3'd3,
      CSR_MAX_DISTANCE = 3'd4,
      CSR_RATIO_Q8     = 3'd5
   } csr_index_type;

   typedef logic [DESC_WORDS-1:0][DESC_WORD_BITS-1:0] query_type;

   typedef struct packed {
      logic [DESC_WORD_BITS-1:0] cand_word0;
      logic [DESC_WORD_BITS-1:0] cand_word1;
      logic [DESC_WORD_BITS-1:0] cand_word2;
      logic [DESC_WORD_BITS-1:0] cand_word3;
      logic [IDX_FIELD_BITS-1:0] cand_index;
      logic                      last_cand;
   } req_type;

   typedef struct packed {
      logic [IDX_FIELD_BITS-1:0] best_index;
      logic [DIST_BITS-1:0]      nearest_dist;
      logic [DIST_BITS-1:0]      second_dist;
      logic                      found;
      logic                      accepted;
   } rsp_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] max_distance;
      logic [DIST_BITS-1:0] ratio_q8;
   } limits_type;

   // queue handshake between front and back
   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // SWAR popcount; byte sums folded with adds instead of the multiply
   function automatic logic [WORD_POP_BITS-1:0] pop64(input logic [DESC_WORD_BITS-1:0] v);
      logic [DESC_WORD_BITS-1:0] a;
      logic [DESC_WORD_BITS-1:0] b;
      logic [DESC_WORD_BITS-1:0] c;
      logic [WORD_POP_BITS-1:0]  s;
      a = v - ((v >> 1) & 64'h5555_5555_5555_5555);
      b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
      c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + WORD_POP_BITS'(c[8*i +: 8]);
      end
      return s;
   endfunction

endpackage

// ===== rtl/core/hbm_front.sv =====
// Front end: takes candidate words, XORs with the query and counts bits.
// Depends on hbm_pkg; pushes distance words into hbm_queue.
module hbm_front
   import hbm_pkg::*;
#(
   parameter int unsigned KEEP_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  query_type                         query,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  req_type                           req_data,
   input  q_stat_type                        q_stat,
   output logic                              q_push,
   output logic [KEEP_BITS+DIST_BITS:0]      q_wdata
);

   logic                                          stage_valid_ff, stage_valid_in;
   logic [DESC_WORDS-1:0][WORD_POP_BITS-1:0]      pop_ff, pop_in;
   logic [KEEP_BITS-1:0]                          idx_ff;
   logic                                          last_ff;
   logic [DIST_BITS-1:0]                          sum_dist;
   logic                                          take;

   assign q_push    = stage_valid_ff & ~q_stat.full;
   assign req_ready = ~stage_valid_ff | ~q_stat.full;
   assign take      = req_valid & req_ready;

   always_comb begin
      pop_in[0] = pop64(req_data.cand_word0 ^ query[0]);
      pop_in[1] = pop64(req_data.cand_word1 ^ query[1]);
      pop_in[2] = pop64(req_data.cand_word2 ^ query[2]);
      pop_in[3] = pop64(req_data.cand_word3 ^ query[3]);
      stage_valid_in = take | (stage_valid_ff & ~q_push);
   end

   assign sum_dist = DIST_BITS'(pop_ff[0]) + DIST_BITS'(pop_ff[1])
                   + DIST_BITS'(pop_ff[2]) + DIST_BITS'(pop_ff[3]);
   assign q_wdata = {last_ff, sum_dist, idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pop_ff  <= pop_in;
         idx_ff  <= req_data.cand_index[KEEP_BITS-1:0];
         last_ff <= req_data.last_cand;
      end
   end

endmodule

// ===== rtl/core/hbm_queue.sv =====
// Short register queue between front and back ends.
// Depends on hbm_pkg for the control and status structs.
module hbm_queue
   import hbm_pkg::*;
#(
   parameter int unsigned DEPTH = 4,
   parameter int unsigned WIDTH = 26
) (
   input  logic              clock,
   input  logic              reset,
   input  q_ctrl_type        q_ctrl,
   output q_stat_type        q_stat,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(DEPTH - 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign q_stat.full  = (count_ff == CNT_BITS'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign rdata        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_ctrl.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_ctrl.pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_ctrl.push && !q_ctrl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_ctrl.pop && !q_ctrl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_ctrl.push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== rtl/core/hbm_back.sv =====
// Back end: running best/second-best search, ratio test and result register.
// Depends on hbm_pkg; pops distance words from hbm_queue.
module hbm_back
   import hbm_pkg::*;
#(
   parameter int unsigned KEEP_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  limits_type                    limits,
   input  q_stat_type                    q_stat,
   output logic                          q_pop,
   input  logic [KEEP_BITS+DIST_BITS:0]  q_rdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rsp_type                       rsp_data
);

   localparam int unsigned PROD_BITS = 2 * DIST_BITS;

   logic [DIST_BITS-1:0] best_ff, best_in;
   logic [DIST_BITS-1:0] second_ff, second_in;
   logic [KEEP_BITS-1:0] idx_ff, idx_in;
   logic                 found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 w_last;
   logic [DIST_BITS-1:0] w_dist;
   logic [KEEP_BITS-1:0] w_idx;
   logic [DIST_BITS-1:0] nb, ns;
   logic [KEEP_BITS-1:0] ni;
   logic                 nf;
   logic [PROD_BITS-1:0] best_scaled;
   logic [PROD_BITS-1:0] ratio_prod;
   logic                 slot_free;

   assign {w_last, w_dist, w_idx} = q_rdata;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   // a last word needs the result slot; others never wait on the receiver
   assign q_pop     = ~q_stat.empty & (~w_last | slot_free);

   always_comb begin
      nb = best_ff;
      ns = second_ff;
      ni = idx_ff;
      nf = found_ff;
      if (w_dist < best_ff) begin
         ns = best_ff;
         nb = w_dist;
         ni = w_idx;
         nf = 1'b1;
      end else if (w_dist < second_ff) begin
         ns = w_dist;
      end

      best_scaled = {1'b0, nb, 8'd0};
      ratio_prod  = {{DIST_BITS{1'b0}}, limits.ratio_q8} * {{DIST_BITS{1'b0}}, ns};

      rsp_in.best_index   = IDX_FIELD_BITS'(ni);
      rsp_in.nearest_dist = nb;
      rsp_in.second_dist  = ns;
      rsp_in.found        = nf;
      rsp_in.accepted     = nf & (nb <= limits.max_distance) & ~(best_scaled > ratio_prod);

      best_in      = best_ff;
      second_in    = second_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (q_pop) begin
         if (w_last) begin
            best_in      = DIST_NONE;
            second_in    = DIST_NONE;
            idx_in       = '0;
            found_in     = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            best_in   = nb;
            second_in = ns;
            idx_in    = ni;
            found_in  = nf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= DIST_NONE;
         second_ff    <= DIST_NONE;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_ff      <= best_in;
         second_ff    <= second_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && w_last) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      q_pop && w_last |=> rsp_valid_ff)
      else $error("last word popped but no result raised");

   a_search_restarts: assert property (@(posedge clock) disable iff (reset)
      q_pop && w_last |=> best_ff == DIST_NONE && second_ff == DIST_NONE && !found_ff)
      else $error("running search not cleared after last word");

   a_order_kept: assert property (@(posedge clock) disable iff (reset)
      second_ff >= best_ff)
      else $error("second-best distance below best");

   a_found_tracks_best: assert property (@(posedge clock) disable iff (reset)
      found_ff == (best_ff != DIST_NONE))
      else $error("found flag out of step with best distance");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(rsp_ff))
      else $error("pending result overwritten");

endmodule

// ===== rtl/core/hamming_best_match_ratio_test.sv =====
// Hamming best-match search with ratio test: top level and config registers.
// Depends on hbm_pkg, hbm_front, hbm_queue and hbm_back.
//
// Usage: the 256-bit query sits in four 64-bit config registers, written
// through csr_wr_en/csr_index/csr_wdata while the block is idle, alongside
// the absolute distance limit and the Q1.8 ratio limit. Candidate words
// stream in on req_*, one per cycle while req_ready is high; the last_cand
// bit closes a search. Only the closing word yields a word on rsp_*: best
// index, best and second-best distance, found and accepted flags.
// Throughput: one candidate per cycle while the queue has room. The front
// stage (XOR and four 64-bit popcounts) is one register deep; the back end
// does the best/second update and the ratio multiply on each word it pops.
// Result path: the closing candidate passes the front stage register and a
// queue slot, then the result register raises rsp_valid.
// Stalls: a held result only stops the back end when another closing word
// reaches it; the queue (QUEUE_DEPTH words) then fills and req_ready drops.
// Reset: synchronous; clears the queue and search state, query to zero,
// max_distance to 50, ratio_q8 to 230. No clearing pass is needed.
module hamming_best_match_ratio_test
   import hbm_pkg::*;
#(
   parameter int unsigned INDEX_BITS  = 16,
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // index bits actually kept: the field is only IDX_FIELD_BITS wide
   localparam int unsigned KEEP_BITS = (INDEX_BITS < IDX_FIELD_BITS) ? INDEX_BITS
                                                                    : IDX_FIELD_BITS;
   localparam int unsigned Q_WIDTH   = KEEP_BITS + DIST_BITS + 1;

   query_type  query_ff;
   limits_type limits_ff;

   q_ctrl_type         q_ctrl;
   q_stat_type         q_stat;
   logic               q_push;
   logic               q_pop;
   logic [Q_WIDTH-1:0] q_wdata;
   logic [Q_WIDTH-1:0] q_rdata;

   assign q_ctrl = '{push: q_push, pop: q_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff               <= '0;
         limits_ff.max_distance <= MAX_DIST_INIT;
         limits_ff.ratio_q8     <= RATIO_INIT;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUERY_WORD0:  query_ff[0] <= csr_wdata;
            CSR_QUERY_WORD1:  query_ff[1] <= csr_wdata;
            CSR_QUERY_WORD2:  query_ff[2] <= csr_wdata;
            CSR_QUERY_WORD3:  query_ff[3] <= csr_wdata;
            CSR_MAX_DISTANCE: limits_ff.max_distance <= csr_wdata[DIST_BITS-1:0];
            CSR_RATIO_Q8:     limits_ff.ratio_q8 <= csr_wdata[DIST_BITS-1:0];
            default: ;
         endcase
      end
   end

   hbm_front #(
      .KEEP_BITS (KEEP_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .query     (query_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   hbm_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (Q_WIDTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_ctrl (q_ctrl),
      .q_stat (q_stat),
      .wdata  (q_wdata),
      .rdata  (q_rdata)
   );

   hbm_back #(
      .KEEP_BITS (KEEP_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .limits    (limits_ff),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .q_rdata   (q_rdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sv/hamming_best_match_ratio_test_tb.sv =====
// Self-checking bench for hamming_best_match_ratio_test: directed table, then random
// searches under several query/limit settings and handshake pacings.
// Depends on hbm_pkg and the RTL under rtl/core.
module hamming_best_match_ratio_test_tb;
   import hbm_pkg::*;

   localparam int unsigned INDEX_BITS    = 16;
   localparam int unsigned IDX_MASK      = (32'h1 << INDEX_BITS) - 1;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          STALL_LIMIT   = 5000;
   localparam int          HOLD_CYCLES   = 300;

   typedef enum {PACE_FREE, PACE_SEND_IDLE, PACE_RSP_STALL, PACE_BOTH} pace_type;

   typedef struct {
      req_type cand;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // predictor copy of the registers and the running search
   logic [255:0] cfg_query;
   int unsigned  cfg_max_dist;
   int unsigned  cfg_ratio;
   int unsigned  cur_best;
   int unsigned  cur_second;
   logic [15:0]  cur_index;
   bit           cur_found;

   rsp_type      pending_matches[$];
   dir_row_type  dir_rows[$];
   int           error_count = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           hold_asked = 0;
   int           hold_seen = 0;
   int           rsp_hold_left = 0;
   int           quiet_cycles = 0;

   hamming_best_match_ratio_test #(.INDEX_BITS(INDEX_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void restart_search();
      cur_best   = 256;
      cur_second = 256;
      cur_index  = '0;
      cur_found  = 1'b0;
   endfunction

   // fold one candidate into the running search; returns 1 when it closes the search
   function automatic bit fold_candidate(input req_type w, output rsp_type r);
      logic [255:0] cand;
      int unsigned  cand_dist;
      logic [15:0]  idx;
      cand      = {w.cand_word3, w.cand_word2, w.cand_word1, w.cand_word0};
      cand_dist = $countones(cand ^ cfg_query);
      idx       = 16'(w.cand_index & IDX_MASK);
      r         = '0;
      if (cand_dist < cur_best) begin
         cur_second = cur_best;
         cur_best   = cand_dist;
         cur_index  = idx;
         cur_found  = 1'b1;
      end else if (cand_dist < cur_second) begin
         cur_second = cand_dist;
      end
      if (!w.last_cand) return 1'b0;
      r.best_index   = cur_index;
      r.nearest_dist = 9'(cur_best);
      r.second_dist  = 9'(cur_second);
      r.found        = cur_found;
      r.accepted     = cur_found && cur_best <= cfg_max_dist
                       && !(cur_best * 256 > cfg_ratio * cur_second);
      restart_search();
      return 1'b1;
   endfunction

   function automatic void add_row(input logic [63:0] w0, input logic [63:0] w1,
                                   input logic [63:0] w2, input logic [63:0] w3,
                                   input logic [15:0] idx, input bit last,
                                   input bit typed, input rsp_type want);
      dir_row_type row;
      row.cand  = '{w0, w1, w2, w3, idx, last};
      row.typed = typed;
      row.want  = want;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   // candidate near the query most of the time, so the limits get exercised
   function automatic req_type gen_cand(input bit last);
      logic [255:0] v;
      int           k;
      int           kind;
      req_type      w;
      kind = $urandom_range(9);
      case (kind)
         0: v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom};
         1: v = cfg_query;
         2: v = ~cfg_query;
         default: begin
            v = cfg_query;
            k = $urandom_range(0, $urandom_range(1) ? 40 : 140);
            for (int i = 0; i < k; i++) v[$urandom_range(255)] = ~v[$urandom_range(255)];
         end
      endcase
      w.cand_word0 = v[63:0];
      w.cand_word1 = v[127:64];
      w.cand_word2 = v[191:128];
      w.cand_word3 = v[255:192];
      w.cand_index = 16'($urandom);
      w.last_cand  = last;
      return w;
   endfunction

   function automatic void set_pace(input pace_type p);
      case (p)
         PACE_FREE:      begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         PACE_SEND_IDLE: begin send_idle_pct = 65; rsp_stall_pct = 0;  end
         PACE_RSP_STALL: begin send_idle_pct = 0;  rsp_stall_pct = 65; end
         PACE_BOTH:      begin send_idle_pct = 16; rsp_stall_pct = 16; end
      endcase
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [63:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_QUERY_WORD0:  cfg_query[63:0]    = data;
         CSR_QUERY_WORD1:  cfg_query[127:64]  = data;
         CSR_QUERY_WORD2:  cfg_query[191:128] = data;
         CSR_QUERY_WORD3:  cfg_query[255:192] = data;
         CSR_MAX_DISTANCE: cfg_max_dist       = data[8:0];
         CSR_RATIO_Q8:     cfg_ratio          = data[8:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_cand(input req_type w, input bit typed, input rsp_type want);
      rsp_type r;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      if (fold_candidate(w, r))
         pending_matches.insert(pending_matches.size(), typed ? want : r);
   endtask

   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_searches(input int n_items, input int max_len);
      int left;
      int len;
      int r;
      left = n_items;
      while (left > 0) begin
         r = $urandom_range(99);
         len = (r < 15) ? 1 : (r < 85) ? $urandom_range(2, 6) : $urandom_range(7, 24);
         if (len > max_len) len = max_len;
         if (len > left) len = left;
         for (int i = 0; i < len; i++) send_cand(gen_cand(i == len - 1), 1'b0, '0);
         left -= len;
      end
   endtask

   // receiver: random stalls, plus a long hold when asked
   always @(negedge clock) begin
      if (hold_asked != hold_seen) begin
         hold_seen     = hold_asked;
         rsp_hold_left = HOLD_CYCLES;
      end
      if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_matches.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result word %p", rsp_data);
         end else begin
            want = pending_matches.pop_front();
            if (rsp_data !== want) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch: exp idx %h best %0d second %0d found %b acc %b",
                           want.best_index, want.nearest_dist, want.second_dist,
                           want.found, want.accepted);
                  $display("          got idx %h best %0d second %0d found %b acc %b",
                           rsp_data.best_index, rsp_data.nearest_dist,
                           rsp_data.second_dist, rsp_data.found, rsp_data.accepted);
               end
            end
         end
      end
   end

   // watchdog: no word moved on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [63:0] max_w;
      logic [63:0] ratio_w;
      logic [63:0] qw[4];
      cfg_query    = '0;
      cfg_max_dist = 50;
      cfg_ratio    = 230;
      restart_search();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows under the reset settings: query zero, limit 50, ratio 230
      add_row('0, '0, '0, '0, 16'h0000, 1'b1, 1'b1, '{16'h0000, 9'd0, 9'd256, 1'b1, 1'b1});
      add_row('1, '1, '1, '1, 16'hFFFF, 1'b1, 1'b1, '{16'h0000, 9'd256, 9'd256, 1'b0, 1'b0});
      // tie with the best keeps the earlier index
      add_row(64'h1, '0, '0, '0, 16'd5, 1'b0, 1'b0, '0);
      add_row(64'h2, '0, '0, '0, 16'd6, 1'b1, 1'b1, '{16'd5, 9'd1, 9'd1, 1'b1, 1'b0});
      // single candidate right at the distance limit, then just over it
      add_row(64'h0003_FFFF_FFFF_FFFF, '0, '0, '0, 16'hFFFF, 1'b1, 1'b1,
              '{16'hFFFF, 9'd50, 9'd256, 1'b1, 1'b1});
      add_row(64'h0007_FFFF_FFFF_FFFF, '0, '0, '0, 16'h8000, 1'b1, 1'b1,
              '{16'h8000, 9'd51, 9'd256, 1'b1, 1'b0});
      add_row('0, 64'h3FF, '0, '0, 16'd1, 1'b0, 1'b0, '0);
      add_row('0, '0, 64'h7, '0, 16'd2, 1'b0, 1'b0, '0);
      add_row('0, '0, '0, 64'h7, 16'd3, 1'b0, 1'b0, '0);
      add_row('1, 64'hFFFF_FFFF_0000_0000, '1, '0, 16'd4, 1'b0, 1'b0, '0);
      add_row('1, '1, '1, '1, 16'd9, 1'b1, 1'b0, '0);
      add_row(64'h3FF, '0, '0, '0, 16'd7, 1'b0, 1'b0, '0);
      add_row('0, '0, 64'hFFFFF, '0, 16'd8, 1'b1, 1'b0, '0);
      add_row(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '0, '1, 16'h1234, 1'b0,
              1'b0, '0);
      add_row('0, '0, '0, 64'h8000_0000_0000_0000, 16'd17, 1'b1, 1'b0, '0);
      // everything at 256 first, then an exact hit
      add_row('1, '1, '1, '1, 16'hAAAA, 1'b0, 1'b0, '0);
      add_row('0, '0, '0, '0, 16'h5555, 1'b1, 1'b0, '0);

      set_pace(PACE_FREE);
      foreach (dir_rows[i]) send_cand(dir_rows[i].cand, dir_rows[i].typed, dir_rows[i].want);
      settle_idle();

      for (int p = 0; p < 12; p++) begin
         for (int j = 0; j < 4; j++) begin
            case ($urandom_range(5))
               0:       qw[j] = '0;
               1:       qw[j] = '1;
               default: qw[j] = {$urandom, $urandom};
            endcase
         end
         case (p % 5)
            0: begin max_w = 64'd0;   ratio_w = 64'd256; end
            1: begin max_w = 64'd256; ratio_w = 64'd0;   end
            2: begin max_w = '1;      ratio_w = '1;      end   // 9-bit fields read as 511
            3: begin
               max_w   = 64'($urandom_range(20, 80));
               ratio_w = 64'($urandom_range(128, 255));
            end
            default: begin max_w = {$urandom, $urandom}; ratio_w = {$urandom, $urandom}; end
         endcase
         write_reg(CSR_QUERY_WORD0, qw[0]);
         write_reg(CSR_QUERY_WORD1, qw[1]);
         write_reg(CSR_QUERY_WORD2, qw[2]);
         write_reg(CSR_QUERY_WORD3, qw[3]);
         write_reg(CSR_MAX_DISTANCE, max_w);
         write_reg(CSR_RATIO_Q8, ratio_w);
         set_pace(pace_type'(p % 4));
         run_searches(140, 24);
         settle_idle();

         // back-pressure: hold the result side while one-word searches keep coming
         if (p == 5) begin
            set_pace(PACE_FREE);
            hold_asked++;
            run_searches(40, 1);
            settle_idle();
         end
      end

      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
